// ===== hdl/spa_pkg.sv =====
// Shared types and constants of the spectrum average / peak-hold block.
package spa_pkg;

  localparam int unsigned MaxBins = 4096;
  localparam int unsigned BinAw   = $clog2(MaxBins);
  localparam int unsigned LvlW    = 16;
  localparam int unsigned CntW    = 13;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 16;
  // one memory word: {avg, peak, line}
  localparam int unsigned WordW   = 3 * LvlW;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegAvgGain   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegPeakHold  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegPeakDecay = 3'd2;
  localparam logic [CfgIdxW-1:0] RegRows      = 3'd3;
  localparam logic [CfgIdxW-1:0] RegBinCount  = 3'd4;

  localparam logic [15:0]     GainFull      = 16'd32768;
  localparam logic [7:0]      DecayReset    = 8'd38;
  localparam logic [7:0]      RowsReset     = 8'd1;
  localparam logic [CntW-1:0] BinCountReset = CntW'(MaxBins);
  localparam logic [CntW-1:0] BinCountMin   = CntW'(2);

  // per-item control carried down the pipeline
  typedef struct packed {
    logic [BinAw-1:0] idx;
    logic             primed;
    logic             line_start;
    logic             peak_on;
    logic             was_on;
    logic             commit;
    logic             last;
  } ctrl_t;

endpackage

// ===== hdl/spa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module spa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/spectrum_average_peak_hold.sv =====
// Spectrum exponential average, peak hold and waterfall line merge (top level).
//
// Bins of one spectrum frame stream in on sample_db_i, bin 0 first; every bin
// gives one result item carrying its index, the updated average, the peak-hold
// level, the running max-merged waterfall value and two flags (line_commit,
// frame_end). The block takes one bin per clock: a bin enters, reads its
// history from a 4096 x 48 RAM ({avg, peak, line} per bin), goes through the
// gain multiply in the next stage, the shift/saturate/peak/max logic in the
// one after, which writes the bin back, and lands in the output register.
// Each bin passes three register stages (stage 1, stage 2, output register).
// in_ready_o only drops while a result waits in the output register and
// out_ready_i is low. A bin whose history was written in the same cycle it
// was read is served from a one-entry bypass register. Configuration writes
// take effect at once and should be made only when the pipeline is empty;
// changing bin_count restarts framing, and the next frame loads all history
// directly. No clearing pass: the first frame after reset or a bin_count
// change writes every entry.
module spectrum_average_peak_hold (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [spa_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [spa_pkg::CfgW-1:0]     cfg_data_i,
  // input items
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [15:0]           sample_db_i,
  // result items
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [11:0]                  bin_index_o,
  output logic signed [15:0]           avg_db_o,
  output logic signed [15:0]           peak_db_o,
  output logic signed [15:0]           line_db_o,
  output logic                         line_commit_o,
  output logic                         frame_end_o
);

  localparam int unsigned AW = spa_pkg::BinAw;
  localparam int unsigned LW = spa_pkg::LvlW;
  localparam int unsigned CW = spa_pkg::CntW;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [15:0]   avg_gain_q;
  logic          peak_hold_q;
  logic [7:0]    peak_decay_q;
  logic [7:0]    rows_q;
  logic [CW-1:0] bin_count_q;
  logic          count_chg;

  assign count_chg = cfg_we_i && (cfg_idx_i == spa_pkg::RegBinCount) &&
                     (cfg_data_i[CW-1:0] != bin_count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_gain_q   <= spa_pkg::GainFull;
      peak_hold_q  <= 1'b0;
      peak_decay_q <= spa_pkg::DecayReset;
      rows_q       <= spa_pkg::RowsReset;
      bin_count_q  <= spa_pkg::BinCountReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        spa_pkg::RegAvgGain:   avg_gain_q   <= cfg_data_i;
        spa_pkg::RegPeakHold:  peak_hold_q  <= cfg_data_i[0];
        spa_pkg::RegPeakDecay: peak_decay_q <= cfg_data_i[7:0];
        spa_pkg::RegRows:      rows_q       <= cfg_data_i[7:0];
        spa_pkg::RegBinCount:  bin_count_q  <= cfg_data_i[CW-1:0];
        default: ;
      endcase
    end
  end

  // effective settings: out-of-range values clamp
  logic [15:0]   gain_eff;
  logic [7:0]    rows_eff;
  logic [CW-1:0] count_eff;

  assign gain_eff = (avg_gain_q > spa_pkg::GainFull) ? spa_pkg::GainFull : avg_gain_q;
  assign rows_eff = (rows_q == 8'd0) ? 8'd1 : rows_q;

  always_comb begin
    count_eff = bin_count_q;
    if (bin_count_q < spa_pkg::BinCountMin) begin
      count_eff = spa_pkg::BinCountMin;
    end else if (bin_count_q > spa_pkg::BinCountReset) begin
      count_eff = spa_pkg::BinCountReset;
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline handshake: every stage moves when the output register frees up
  // ---------------------------------------------------------------------------
  logic advance;
  logic in_acc;
  logic v1_q, v2_q, out_valid_q;

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = advance;
  assign in_acc     = in_valid_i && advance;

  // ---------------------------------------------------------------------------
  // Stage 0: framing counters, RAM read issue
  // ---------------------------------------------------------------------------
  logic [AW-1:0] bin_pos_q;
  logic [7:0]    frames_q;
  logic          primed_q;
  logic          was_on_q;

  logic [AW-1:0]   pos;
  logic [CW-1:0]   pos_inc;
  logic [7:0]      n_eff;
  logic [8:0]      n_inc;
  spa_pkg::ctrl_t  c0;

  always_comb begin
    pos           = ({1'b0, bin_pos_q} >= count_eff) ? '0 : bin_pos_q;
    pos_inc       = {1'b0, pos} + CW'(1);
    n_eff         = primed_q ? frames_q : 8'd0;
    n_inc         = {1'b0, n_eff} + 9'd1;
    c0.idx        = pos;
    c0.primed     = primed_q;
    c0.line_start = !primed_q || (frames_q == 8'd0);
    c0.peak_on    = peak_hold_q;
    c0.was_on     = was_on_q;
    c0.commit     = n_inc >= {1'b0, rows_eff};
    c0.last       = pos_inc >= count_eff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_pos_q <= '0;
      frames_q  <= '0;
      primed_q  <= 1'b0;
      was_on_q  <= 1'b0;
    end else if (count_chg) begin
      bin_pos_q <= '0;
      frames_q  <= '0;
      primed_q  <= 1'b0;
    end else if (in_acc) begin
      if (c0.last) begin
        bin_pos_q <= '0;
        primed_q  <= 1'b1;
        was_on_q  <= peak_hold_q;
        if (c0.commit) begin
          frames_q <= '0;
        end else begin
          frames_q <= n_inc[8] ? 8'd255 : n_inc[7:0];
        end
      end else begin
        bin_pos_q <= pos + AW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // History RAM and same-cycle bypass
  // ---------------------------------------------------------------------------
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [spa_pkg::WordW-1:0]   ram_wdata;
  logic [spa_pkg::WordW-1:0]   ram_rdata;
  logic                        byp_q;
  logic [spa_pkg::WordW-1:0]   byp_data_q;

  spa_ram #(
    .Width (spa_pkg::WordW),
    .Depth (spa_pkg::MaxBins)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (advance),
    .raddr_i (pos),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Stage 1: pick history, difference and gain multiply
  // ---------------------------------------------------------------------------
  spa_pkg::ctrl_t             c1_q;
  logic signed [LW-1:0]       x1_q;
  logic [spa_pkg::WordW-1:0]  hist1;
  logic signed [LW-1:0]       old1, pk1, ln1;
  logic signed [LW:0]         diff1;
  logic signed [2*LW+1:0]     prod1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      byp_q <= 1'b0;
    end else if (advance) begin
      v1_q  <= in_acc;
      byp_q <= ram_we && (ram_waddr == pos);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      c1_q       <= c0;
      x1_q       <= sample_db_i;
      byp_data_q <= ram_wdata;
    end
  end

  always_comb begin
    hist1 = byp_q ? byp_data_q : ram_rdata;
    old1  = hist1[3*LW-1:2*LW];
    pk1   = hist1[2*LW-1:LW];
    ln1   = hist1[LW-1:0];
    diff1 = {x1_q[LW-1], x1_q} - {old1[LW-1], old1};
    prod1 = (2*LW+2)'(diff1) * (2*LW+2)'($signed({1'b0, gain_eff}));
  end

  // ---------------------------------------------------------------------------
  // Stage 2: floor shift, saturate, peak and line update, write back
  // ---------------------------------------------------------------------------
  spa_pkg::ctrl_t          c2_q;
  logic signed [LW-1:0]    x2_q, old2_q, pk2_q, ln2_q;
  logic signed [2*LW+1:0]  prod2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (advance) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      c2_q    <= c1_q;
      x2_q    <= x1_q;
      old2_q  <= old1;
      pk2_q   <= pk1;
      ln2_q   <= ln1;
      prod2_q <= prod1;
    end
  end

  logic signed [LW+2:0]   delta, sum;
  logic signed [LW-1:0]   avg2, peak2, line2, prior;
  logic signed [LW:0]     dropped;

  always_comb begin
    // floor division by 2^15: arithmetic shift of the product
    delta   = prod2_q[2*LW+1:LW-1];
    sum     = (LW+3)'(old2_q) + delta;
    if (sum > (LW+3)'(32767)) begin
      avg2 = 16'sh7FFF;
    end else if (sum < -(LW+3)'(32768)) begin
      avg2 = 16'sh8000;
    end else begin
      avg2 = sum[LW-1:0];
    end

    // hold just switched on: restart from the old average
    prior   = c2_q.was_on ? pk2_q : old2_q;
    dropped = (LW+1)'(prior) - (LW+1)'($signed({9'd0, peak_decay_q}));
    if (dropped < -(LW+1)'(32768)) begin
      dropped = -(LW+1)'(32768);
    end
    if (c2_q.peak_on) begin
      peak2 = (dropped > (LW+1)'(avg2)) ? dropped[LW-1:0] : avg2;
    end else begin
      peak2 = pk2_q;
    end

    if (!c2_q.primed) begin
      avg2  = x2_q;
      peak2 = x2_q;
    end

    if (c2_q.line_start) begin
      line2 = x2_q;
    end else begin
      line2 = (ln2_q > x2_q) ? ln2_q : x2_q;
    end
  end

  assign ram_we    = v2_q && advance;
  assign ram_waddr = c2_q.idx;
  assign ram_wdata = {avg2, peak2, line2};

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic [11:0]          idx_o_q;
  logic signed [LW-1:0] avg_o_q, peak_o_q, line_o_q;
  logic                 commit_o_q, last_o_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      idx_o_q    <= 12'(c2_q.idx);
      avg_o_q    <= avg2;
      peak_o_q   <= peak2;
      line_o_q   <= line2;
      commit_o_q <= c2_q.commit;
      last_o_q   <= c2_q.last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign bin_index_o   = idx_o_q;
  assign avg_db_o      = avg_o_q;
  assign peak_db_o     = peak_o_q;
  assign line_db_o     = line_o_q;
  assign line_commit_o = commit_o_q;
  assign frame_end_o   = last_o_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // neighbors in the pipeline never share a bin, so no stage-2 forward is needed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && v2_q |-> c1_q.idx != c2_q.idx)
    else $error("adjacent pipeline items address the same bin");

  // a held peak never sits below the average it was built from
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && c2_q.primed && c2_q.peak_on |-> peak2 >= avg2)
    else $error("peak hold fell below average");

  // frame end marks the last bin of the frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && c2_q.last |-> ({1'b0, c2_q.idx} + CW'(1)) == count_eff)
    else $error("frame end on wrong bin");

  // an accepted bin whose history is written as it is read takes the bypass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_acc && ram_we && (ram_waddr == pos) |=> byp_q && v1_q)
    else $error("bypass not taken on same-cycle write");

endmodule

// ===== tb/sv/spectrum_average_peak_hold_test.sv =====
// Self-checking testbench for the spectrum average / peak-hold block.
module spectrum_average_peak_hold_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 8;  // pipeline is three deep, leave some slack

  // one result item as it leaves the block
  typedef struct {
    logic [11:0]        bin_index;
    logic signed [15:0] avg_db;
    logic signed [15:0] peak_db;
    logic signed [15:0] line_db;
    logic               line_commit;
    logic               frame_end;
  } bin_result_t;

  // Tracks per-bin history the way the block should, and checks result items
  // in order against the levels it worked out for each accepted bin.
  class level_tracker;
    bin_result_t              expected_q[$];
    int unsigned              mismatches;
    logic signed [15:0]       avg_mem   [spa_pkg::MaxBins];
    logic signed [15:0]       peak_mem  [spa_pkg::MaxBins];
    logic signed [15:0]       merge_mem [spa_pkg::MaxBins];
    int unsigned              pos;
    int unsigned              merged;
    bit                       primed;
    bit                       was_on;
    logic [15:0]              gain_r;
    bit                       hold_r;
    logic [7:0]               decay_r;
    logic [7:0]               rows_r;
    logic [spa_pkg::CntW-1:0] count_r;

    function new();
      mismatches = 0;
      pos        = 0;
      merged     = 0;
      primed     = 0;
      was_on     = 0;
      gain_r     = spa_pkg::GainFull;
      hold_r     = 0;
      decay_r    = spa_pkg::DecayReset;
      rows_r     = spa_pkg::RowsReset;
      count_r    = spa_pkg::BinCountReset;
    endfunction

    function void write_reg(logic [spa_pkg::CfgIdxW-1:0] idx, logic [15:0] data);
      case (idx)
        spa_pkg::RegAvgGain:   gain_r  = data;
        spa_pkg::RegPeakHold:  hold_r  = data[0];
        spa_pkg::RegPeakDecay: decay_r = data[7:0];
        spa_pkg::RegRows:      rows_r  = data[7:0];
        spa_pkg::RegBinCount: begin
          // only a real change of the frame size restarts framing
          if (data[spa_pkg::CntW-1:0] != count_r) begin
            count_r = data[spa_pkg::CntW-1:0];
            pos     = 0;
            merged  = 0;
            primed  = 0;
          end
        end
        default: ;
      endcase
    endfunction

    function void take_bin(logic signed [15:0] sample);
      int          x;
      int          old;
      int          avg;
      int          peak;
      int          prior;
      int          dropped;
      int          line;
      int unsigned cnt;
      int unsigned rows;
      int unsigned n;
      int          g;
      longint      prod;
      bit          commit;
      bit          last;
      bin_result_t want;
      x    = sample;
      cnt  = count_r;
      if (cnt < 2) cnt = 2;
      if (cnt > spa_pkg::MaxBins) cnt = spa_pkg::MaxBins;
      rows = (rows_r == 0) ? 1 : rows_r;
      g    = (gain_r > spa_pkg::GainFull) ? int'(spa_pkg::GainFull) : int'(gain_r);
      if (pos >= cnt) pos = 0;

      if (!primed) begin
        avg  = x;
        peak = x;
      end else begin
        old  = avg_mem[pos];
        prod = longint'(x - old) * longint'(g);
        avg  = old + int'(prod >>> 15);  // floor division by 2^15
        if (avg > 32767) avg = 32767;
        if (avg < -32768) avg = -32768;
        peak = peak_mem[pos];
        if (hold_r) begin
          // hold just switched on: restart from the old average
          prior   = was_on ? peak : old;
          dropped = prior - int'(decay_r);
          if (dropped < -32768) dropped = -32768;
          peak = (dropped > avg) ? dropped : avg;
        end
      end

      if (!primed || merged == 0) begin
        line = x;
      end else begin
        line = merge_mem[pos];
        if (x > line) line = x;
      end

      avg_mem[pos]   = avg[15:0];
      peak_mem[pos]  = peak[15:0];
      merge_mem[pos] = line[15:0];

      commit = ((primed ? merged : 0) + 1) >= rows;
      last   = (pos + 1) >= cnt;

      want.bin_index   = pos[11:0];
      want.avg_db      = avg[15:0];
      want.peak_db     = peak[15:0];
      want.line_db     = line[15:0];
      want.line_commit = commit;
      want.frame_end   = last;
      expected_q.push_back(want);

      if (last) begin
        n      = primed ? merged : 0;
        pos    = 0;
        merged = commit ? 0 : ((n + 1 > 255) ? 255 : n + 1);
        primed = 1;
        was_on = hold_r;
      end else begin
        pos++;
      end
    endfunction

    function void check_bin(logic [11:0] bin_index, logic signed [15:0] avg_db,
                            logic signed [15:0] peak_db, logic signed [15:0] line_db,
                            logic line_commit, logic frame_end);
      bin_result_t want;
      if (expected_q.size() == 0) begin
        $error("result item with no bin pending: bin_index %0d", bin_index);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      if (bin_index !== want.bin_index) begin
        $error("bin_index: expected %0d, actual %0d", want.bin_index, bin_index);
        mismatches++;
      end
      if (avg_db !== want.avg_db) begin
        $error("avg_db: expected %0d, actual %0d", want.avg_db, avg_db);
        mismatches++;
      end
      if (peak_db !== want.peak_db) begin
        $error("peak_db: expected %0d, actual %0d", want.peak_db, peak_db);
        mismatches++;
      end
      if (line_db !== want.line_db) begin
        $error("line_db: expected %0d, actual %0d", want.line_db, line_db);
        mismatches++;
      end
      if (line_commit !== want.line_commit) begin
        $error("line_commit: expected %0d, actual %0d", want.line_commit, line_commit);
        mismatches++;
      end
      if (frame_end !== want.frame_end) begin
        $error("frame_end: expected %0d, actual %0d", want.frame_end, frame_end);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_we = 1'b0;
  logic [spa_pkg::CfgIdxW-1:0] cfg_idx = spa_pkg::RegAvgGain;
  logic [spa_pkg::CfgW-1:0]    cfg_data = '0;
  logic                        in_valid = 1'b0;
  logic                        in_ready_o;
  logic signed [15:0]          sample_db = '0;
  logic                        out_valid_o;
  logic                        out_ready = 1'b0;
  logic [11:0]                 bin_index_o;
  logic signed [15:0]          avg_db_o;
  logic signed [15:0]          peak_db_o;
  logic signed [15:0]          line_db_o;
  logic                        line_commit_o;
  logic                        frame_end_o;

  // idle and stall odds in percent per cycle, set per phase
  int unsigned in_idle_pct   = 0;
  int unsigned out_stall_pct = 0;
  int unsigned cycle_count   = 0;

  level_tracker levels = new();

  spectrum_average_peak_hold u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready_o),
    .sample_db_i   (sample_db),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready),
    .bin_index_o   (bin_index_o),
    .avg_db_o      (avg_db_o),
    .peak_db_o     (peak_db_o),
    .line_db_o     (line_db_o),
    .line_commit_o (line_commit_o),
    .frame_end_o   (frame_end_o)
  );

  always #5 clk_i = ~clk_i;

  // receiver: random back-pressure at the current stall rate
  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  // Monitor. Everything the TB drives changes in the NBA region, so values read
  // here are the ones the DUT saw at this edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready_o) levels.take_bin(sample_db);
      if (out_valid_o && out_ready) begin
        levels.check_bin(bin_index_o, avg_db_o, peak_db_o, line_db_o,
                         line_commit_o, frame_end_o);
      end
    end
  end

  // hard stop if the block hangs
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // Offer one bin; returns in the time step of the edge that accepted it.
  // valid stays high between back-to-back bins, so it is never dropped and
  // raised in the same step.
  task automatic send_bin(input logic signed [15:0] level);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    sample_db <= level;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // stop offering bins, then wait for every pending result plus pipeline slack
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (levels.pending() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // write all five registers back to back; only called with the block idle
  task automatic program_regs(input logic [15:0] gain, input logic [15:0] hold,
                              input logic [15:0] decay, input logic [15:0] rows,
                              input logic [15:0] count);
    logic [spa_pkg::CfgIdxW-1:0] idx_list [5];
    logic [15:0]                 val_list [5];
    idx_list = '{spa_pkg::RegAvgGain, spa_pkg::RegPeakHold, spa_pkg::RegPeakDecay,
                 spa_pkg::RegRows, spa_pkg::RegBinCount};
    val_list = '{gain, hold, decay, rows, count};
    for (int i = 0; i < 5; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= idx_list[i];
      cfg_data <= val_list[i];
      @(posedge clk_i);
      levels.write_reg(idx_list[i], val_list[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // level mix: rails, full-range noise and a band around a noise floor
  function automatic logic signed [15:0] rand_level();
    case ($urandom_range(9))
      0:       return -16'sd32768;
      1:       return 16'sd32767;
      2, 3, 4: return 16'($urandom);
      default: return 16'(-2560 + int'($urandom_range(1536)));
    endcase
  endfunction

  initial begin
    int unsigned idle_pct_by_mode  [4];
    int unsigned stall_pct_by_mode [4];
    logic [15:0] gain;
    logic [7:0]  rows_lo;
    logic [12:0] count_lo;
    logic [12:0] cur_count;
    int unsigned mode;
    idle_pct_by_mode  = '{0, 60, 0, 14};
    stall_pct_by_mode = '{0, 0, 60, 14};
    cur_count = spa_pkg::BinCountReset;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed ---
    // reset settings: partial 4096-bin first frame, rails and zero
    send_bin(-16'sd32768);
    send_bin(16'sd32767);
    send_bin(16'sd0);
    send_bin(-16'sd1);
    wait_idle();

    // smallest frame, rows 0 acts as 1, max decay with hold on:
    // second frame drives the peak droop into its negative clamp
    program_regs(spa_pkg::GainFull, 16'h0001, 16'h00FF, 16'h0000, 16'd2);
    cur_count = 13'd2;
    send_bin(-16'sd32768);
    send_bin(16'sd32767);
    send_bin(-16'sd32768);
    send_bin(-16'sd32768);
    send_bin(16'sd32767);
    send_bin(16'sd0);
    wait_idle();

    // gain 0 freezes the average, bin_count 1 acts as 2 (restart), 255 rows
    program_regs(16'd0, 16'h0000, 16'h0000, 16'h00FF, 16'd1);
    cur_count = 13'd1;
    send_bin(16'sd100);
    send_bin(-16'sd100);
    send_bin(16'sd32767);
    send_bin(-16'sd32768);
    send_bin(16'sd5);
    send_bin(16'sd6);
    wait_idle();

    // hold switched on mid-stream: peaks restart from the old averages;
    // gain above full scale acts as full scale; same bin_count, no restart
    program_regs(16'hFFFF, 16'h0001, 16'd38, 16'd3, 16'd1);
    send_bin(16'sd0);
    send_bin(16'sd32767);
    send_bin(-16'sd32768);
    send_bin(16'sd1000);
    send_bin(16'sd7);
    send_bin(16'sd7);
    send_bin(-16'sd7);
    send_bin(-16'sd7);
    wait_idle();

    // smallest nonzero gain, hold off with junk in the upper data bits
    program_regs(16'd1, 16'hFFFE, 16'h0000, 16'd2, 16'd3);
    cur_count = 13'd3;
    send_bin(16'sd32767);
    send_bin(-16'sd32768);
    send_bin(16'sd0);
    send_bin(-16'sd32768);
    send_bin(16'sd32767);
    send_bin(16'sd1);
    wait_idle();

    // --- random phases: small frames, every idle mode in turn ---
    for (int phase = 0; phase < 16; phase++) begin
      mode          = phase % 4;
      in_idle_pct   = idle_pct_by_mode[mode];
      out_stall_pct = stall_pct_by_mode[mode];
      case ($urandom_range(4))
        0:       gain = spa_pkg::GainFull;
        1:       gain = 16'($urandom_range(1, 32768));
        2:       gain = 16'($urandom_range(32769, 65535));
        3:       gain = 16'd0;
        default: gain = 16'($urandom_range(1, 64));
      endcase
      case ($urandom_range(3))
        0:       rows_lo = 8'd0;
        1:       rows_lo = 8'd255;
        default: rows_lo = 8'($urandom_range(1, 5));
      endcase
      case ($urandom_range(5))
        0:       count_lo = cur_count;  // same size: history carries over
        1:       count_lo = 13'($urandom_range(1));
        default: count_lo = 13'($urandom_range(2, 24));
      endcase
      cur_count = count_lo;
      program_regs(gain, 16'($urandom), 16'($urandom), {8'($urandom), rows_lo},
                   {3'($urandom), count_lo});
      repeat (70) send_bin(rand_level());
      wait_idle();
    end

    // --- size above the maximum clamps to 4096; the frame stays open ---
    in_idle_pct   = 0;
    out_stall_pct = 0;
    program_regs(16'($urandom_range(1, 32768)), 16'h0001, 16'($urandom), 16'd2,
                 16'($urandom_range(spa_pkg::MaxBins + 1, 8191)));
    repeat (40) send_bin(rand_level());
    wait_idle();

    if (levels.mismatches == 0 && levels.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/spa_pkg.sv
hdl/spa_ram.sv
hdl/spectrum_average_peak_hold.sv
tb/sv/spectrum_average_peak_hold_test.sv
